### rtl/zrp_pkg.sv
// Shared types, constants and helpers of the zero-range process step block.
`default_nettype none
package zrp_pkg;

    localparam int MAX_SITES  = 1024;
    localparam int ADDR_W     = $clog2(MAX_SITES);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int COUNT_BITS = 16;
    localparam int TOTAL_W    = 36;
    localparam int WEIGHT_W   = 24;
    localparam int DIV_W      = 32;
    localparam int DIV_STEP   = 8;
    localparam int DIV_ITER   = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER);

    localparam logic [DIV_W:0]          WEIGHT_ONE = (DIV_W+1)'(65536);
    localparam logic [WEIGHT_W-1:0]     WEIGHT_MAX = {WEIGHT_W{1'b1}};
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX  = {COUNT_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_SITES = 2'd0;
    localparam logic [1:0] CFG_INTER_B   = 2'd1;
    localparam logic [1:0] CFG_TAG_CLASS = 2'd2;

    localparam logic [LEN_W-1:0] NUM_SITES_RST = LEN_W'(MAX_SITES);
    localparam logic [WEIGHT_W-1:0] INTER_B_RST = WEIGHT_W'(65536);
    localparam logic [1:0] TAG_CLASS_RST = 2'd3;
    localparam logic [1:0] TAG_ALWAYS    = 2'd1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TAG   = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MUL, S_MUL2,
        S_SCAN_RD, S_SCAN_DAT, S_SCAN_DIV, S_SCAN_ACC,
        S_NXT_RD, S_NXT_DAT, S_UPD_W, S_UPD_DIV, S_UPD_ACC,
        S_TAG, S_TAG_DIV, S_WR1, S_WR2, S_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      dividend;
        logic [COUNT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIV_W-1:0]      quotient;
        logic [COUNT_BITS-1:0] remainder;
    } t_div_rsp;

    // Site weight from quotient b/n: one plus quotient, saturated
    function automatic logic [WEIGHT_W-1:0] weight_sat(input logic [DIV_W-1:0] q);
        logic [DIV_W:0] s;
        s = {1'b0, q} + WEIGHT_ONE;
        if (s > (DIV_W+1)'(WEIGHT_MAX)) begin
            return WEIGHT_MAX;
        end
        return s[WEIGHT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/zrp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module zrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/zrp_div.sv
// Iterative restoring divider, several quotient bits per cycle.
`default_nettype none
module zrp_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire zrp_pkg::t_div_req i_req,
    output      zrp_pkg::t_div_rsp o_rsp
);
    import zrp_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [COUNT_BITS:0]   r_rem, n_rem;
    logic [DIV_W-1:0]      r_quo, n_quo;
    logic [COUNT_BITS-1:0] r_dvs, n_dvs;

    // Next partial remainder and quotient
    always_comb begin
        logic [COUNT_BITS:0] rem;
        logic [DIV_W-1:0]    quo;
        rem    = r_rem;
        quo    = r_quo;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            rem    = '0;
            quo    = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            for (int k = 0; k < DIV_STEP; k++) begin
                rem = {rem[COUNT_BITS-1:0], quo[DIV_W-1]};
                quo = {quo[DIV_W-2:0], 1'b0};
                if (rem >= {1'b0, r_dvs}) begin
                    rem    = rem - {1'b0, r_dvs};
                    quo[0] = 1'b1;
                end
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[COUNT_BITS-1:0];
endmodule
`default_nettype wire

### rtl/zero_range_process_step.sv
// Top level: ring zero-range process step with occupancy memory and tagged particle.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+-------------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_command i_site_index i_site_count i_dice
//          |            |             | i_direction i_tag_draw
//  out     | o_out_valid| i_out_ready | o_status o_chosen_site o_target_site
//          |            |             | o_tagged_site o_tag_moved
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_index i_cfg_data
//
// Each site weight needs one read of the occupancy RAM; an occupied site also needs one
// pass of the shared divider, while an empty site gets weight zero without it. A step
// adds the scaling of the draw before the scan and the move update after it.
// After reset a clearing pass zeroes all 1024 RAM entries; no request is taken then.
// One request is worked at a time; a finished result waits in the output register.
`default_nettype none
module zero_range_process_step (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [1:0]                     i_command,
    input  wire logic [zrp_pkg::ADDR_W-1:0]     i_site_index,
    input  wire logic [zrp_pkg::COUNT_BITS-1:0] i_site_count,
    input  wire logic [31:0]                    i_dice,
    input  wire logic                           i_direction,
    input  wire logic [30:0]                    i_tag_draw,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic [1:0]                     o_status,
    output      logic [zrp_pkg::ADDR_W-1:0]     o_chosen_site,
    output      logic [zrp_pkg::ADDR_W-1:0]     o_target_site,
    output      logic [zrp_pkg::ADDR_W-1:0]     o_tagged_site,
    output      logic                           o_tag_moved,
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [23:0]                    i_cfg_data
);
    import zrp_pkg::*;

    t_state                r_state, n_state;
    logic [LEN_W-1:0]      r_num_sites;
    logic [WEIGHT_W-1:0]   r_inter_b;
    logic [1:0]            r_tag_class;
    logic [1:0]            r_cmd, n_cmd;
    logic [ADDR_W-1:0]     r_site, n_site;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [ADDR_W-1:0]     r_clr, n_clr;
    logic [31:0]           r_dice, n_dice;
    logic                  r_dir, n_dir;
    logic [30:0]           r_draw, n_draw;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [ADDR_W-1:0]     r_tag, n_tag;
    logic [TOTAL_W-1:0]    r_run, n_run;
    logic [TOTAL_W-1:0]    r_scaled, n_scaled;
    logic [63:0]           r_prod_lo, n_prod_lo;
    logic [TOTAL_W-1:0]    r_prod_hi, n_prod_hi;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_nc, n_nc;
    logic [COUNT_BITS-1:0] r_nn, n_nn;
    logic [WEIGHT_W-1:0]   r_w, n_w;
    logic [TOTAL_W-1:0]    r_t, n_t;
    logic [1:0]            r_phase, n_phase;
    logic [ADDR_W-1:0]     r_cur, n_cur;
    logic [ADDR_W-1:0]     r_nxt, n_nxt;
    logic                  r_moved, n_moved;
    logic [1:0]            r_stat, n_stat;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out_status, n_out_status;
    logic [ADDR_W-1:0]     r_out_chosen, n_out_chosen;
    logic [ADDR_W-1:0]     r_out_target, n_out_target;
    logic [ADDR_W-1:0]     r_out_tagged, n_out_tagged;
    logic                  r_out_moved, n_out_moved;

    logic [LEN_W-1:0]      len;
    logic                  in_acc;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    // Ring length in use, clamped to the supported range
    always_comb begin
        if (r_num_sites < LEN_W'(2)) begin
            len = LEN_W'(2);
        end else if (r_num_sites > LEN_W'(MAX_SITES)) begin
            len = LEN_W'(MAX_SITES);
        end else begin
            len = r_num_sites;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    zrp_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_SITES)) u_occ (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    zrp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer: next state, datapath updates, RAM and divider requests
    always_comb begin
        logic [TOTAL_W-1:0]    run;
        logic [COUNT_BITS-1:0] wn;
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_site       = r_site;
        n_idx        = r_idx;
        n_clr        = r_clr;
        n_dice       = r_dice;
        n_dir        = r_dir;
        n_draw       = r_draw;
        n_total      = r_total;
        n_tag        = r_tag;
        n_run        = r_run;
        n_scaled     = r_scaled;
        n_prod_lo    = r_prod_lo;
        n_prod_hi    = r_prod_hi;
        n_cnt        = r_cnt;
        n_nc         = r_nc;
        n_nn         = r_nn;
        n_w          = r_w;
        n_t          = r_t;
        n_phase      = r_phase;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_moved      = r_moved;
        n_stat       = r_stat;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_chosen = r_out_chosen;
        n_out_target = r_out_target;
        n_out_tagged = r_out_tagged;
        n_out_moved  = r_out_moved;
        ram_we       = 1'b0;
        ram_waddr    = r_cur;
        ram_wdata    = '0;
        ram_raddr    = (r_state == S_NXT_RD) ? r_nxt : r_idx;
        div_req      = '{start: 1'b0, dividend: DIV_W'(r_inter_b), divisor: '0};
        run          = r_run + TOTAL_W'(r_w);
        unique case (r_phase)
            2'd0:    wn = r_nn;
            2'd1:    wn = r_nc - 1'b1;
            default: wn = r_nn + 1'b1;
        endcase

        unique case (r_state)
            // Zero the RAM one entry a cycle
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_W'(MAX_SITES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // Take a request; site writes complete here
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_command;
                    n_site  = i_site_index;
                    n_dice  = i_dice;
                    n_dir   = i_direction;
                    n_draw  = i_tag_draw;
                    n_cur   = '0;
                    n_nxt   = '0;
                    n_moved = 1'b0;
                    n_stat  = ST_OK;
                    n_idx   = '0;
                    n_run   = '0;
                    unique case (t_cmd'(i_command))
                        CMD_WRITE: begin
                            n_state = S_OUT;
                            if ({1'b0, i_site_index} >= len) begin
                                n_stat = ST_RANGE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = i_site_index;
                                ram_wdata = i_site_count;
                            end
                        end
                        CMD_TAG: begin
                            if ({1'b0, i_site_index} >= len) begin
                                n_stat  = ST_RANGE;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        CMD_STEP: n_state = S_MUL;
                        CMD_NONE: n_state = S_OUT;
                    endcase
                end
            end
            // Scale the draw by the total in two partial products
            S_MUL: begin
                n_prod_lo = 64'(r_dice) * 64'(r_total[31:0]);
                n_prod_hi = TOTAL_W'(r_dice) * TOTAL_W'(r_total[TOTAL_W-1:32]);
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                n_scaled = r_prod_hi + TOTAL_W'(r_prod_lo[63:32]);
                n_state  = S_SCAN_RD;
            end
            // Walk the sites: read count, get weight, accumulate
            S_SCAN_RD: n_state = S_SCAN_DAT;
            S_SCAN_DAT: begin
                n_cnt = ram_rdata;
                if (ram_rdata == '0) begin
                    n_w     = '0;
                    n_state = S_SCAN_ACC;
                end else begin
                    div_req.start   = 1'b1;
                    div_req.divisor = ram_rdata;
                    n_state         = S_SCAN_DIV;
                end
            end
            S_SCAN_DIV: begin
                if (div_rsp.done) begin
                    n_w     = weight_sat(div_rsp.quotient);
                    n_state = S_SCAN_ACC;
                end
            end
            S_SCAN_ACC: begin
                n_run = run;
                n_idx = r_idx + 1'b1;
                if (t_cmd'(r_cmd) == CMD_TAG) begin
                    if ({1'b0, r_idx} + 1'b1 == len) begin
                        n_total = run;
                        n_tag   = r_site;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else if (r_scaled < run) begin
                    n_cur = r_idx;
                    n_nc  = r_cnt;
                    n_t   = r_total - TOTAL_W'(r_w);
                    if (r_dir) begin
                        n_nxt = ({1'b0, r_idx} + 1'b1 == len) ? '0 : r_idx + 1'b1;
                    end else begin
                        n_nxt = (r_idx == '0) ? ADDR_W'(len - 1'b1) : r_idx - 1'b1;
                    end
                    n_state = S_NXT_RD;
                end else if ({1'b0, r_idx} + 1'b1 == len) begin
                    n_stat  = ST_ZERO;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            // Fetch the target count and check for overflow
            S_NXT_RD: n_state = S_NXT_DAT;
            S_NXT_DAT: begin
                n_nn    = ram_rdata;
                n_phase = 2'd0;
                if (ram_rdata == COUNT_MAX) begin
                    n_stat  = ST_OVERFLOW;
                    n_state = S_OUT;
                end else begin
                    n_state = S_UPD_W;
                end
            end
            // Adjust the total: drop w(nn), add w(nc-1) and w(nn+1)
            S_UPD_W: begin
                if (wn == '0) begin
                    n_w     = '0;
                    n_state = S_UPD_ACC;
                end else begin
                    div_req.start   = 1'b1;
                    div_req.divisor = wn;
                    n_state         = S_UPD_DIV;
                end
            end
            S_UPD_DIV: begin
                if (div_rsp.done) begin
                    n_w     = weight_sat(div_rsp.quotient);
                    n_state = S_UPD_ACC;
                end
            end
            S_UPD_ACC: begin
                n_t     = (r_phase == 2'd0) ? r_t - TOTAL_W'(r_w) : r_t + TOTAL_W'(r_w);
                n_phase = r_phase + 1'b1;
                n_state = (r_phase == 2'd2) ? S_TAG : S_UPD_W;
            end
            // Decide whether the tagged particle follows
            S_TAG: begin
                if (r_cur == r_tag) begin
                    if (r_tag_class == TAG_ALWAYS) begin
                        n_moved = 1'b1;
                        n_state = S_WR1;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(r_draw);
                        div_req.divisor  = r_nc;
                        n_state          = S_TAG_DIV;
                    end
                end else begin
                    n_state = S_WR1;
                end
            end
            S_TAG_DIV: begin
                if (div_rsp.done) begin
                    n_moved = (div_rsp.remainder == '0);
                    n_state = S_WR1;
                end
            end
            // Write back both counts and commit the total
            S_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = r_nc - 1'b1;
                n_state   = S_WR2;
            end
            S_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_nxt;
                ram_wdata = r_nn + 1'b1;
                n_total   = r_t;
                if (r_moved) begin
                    n_tag = r_nxt;
                end
                n_state = S_OUT;
            end
            // Hold until the output register is free, then load it
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_stat;
                    n_out_chosen = r_cur;
                    n_out_target = r_nxt;
                    n_out_tagged = r_tag;
                    n_out_moved  = r_moved;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_tag       <= '0;
            r_num_sites <= NUM_SITES_RST;
            r_inter_b   <= INTER_B_RST;
            r_tag_class <= TAG_CLASS_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_tag       <= n_tag;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_NUM_SITES: r_num_sites <= i_cfg_data[LEN_W-1:0];
                    CFG_INTER_B:   r_inter_b   <= i_cfg_data;
                    CFG_TAG_CLASS: r_tag_class <= i_cfg_data[1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_site       <= n_site;
        r_idx        <= n_idx;
        r_dice       <= n_dice;
        r_dir        <= n_dir;
        r_draw       <= n_draw;
        r_run        <= n_run;
        r_scaled     <= n_scaled;
        r_prod_lo    <= n_prod_lo;
        r_prod_hi    <= n_prod_hi;
        r_cnt        <= n_cnt;
        r_nc         <= n_nc;
        r_nn         <= n_nn;
        r_w          <= n_w;
        r_t          <= n_t;
        r_phase      <= n_phase;
        r_cur        <= n_cur;
        r_nxt        <= n_nxt;
        r_moved      <= n_moved;
        r_stat       <= n_stat;
        r_out_status <= n_out_status;
        r_out_chosen <= n_out_chosen;
        r_out_target <= n_out_target;
        r_out_tagged <= n_out_tagged;
        r_out_moved  <= n_out_moved;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_chosen_site = r_out_chosen;
    assign o_target_site = r_out_target;
    assign o_tagged_site = r_out_tagged;
    assign o_tag_moved   = r_out_moved;

    // Divider is only started when idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Scan never passes the end of the ring
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_ACC) |-> ({1'b0, r_idx} < len))
        else $error("scan index beyond ring length");

    // One request at a time: no accept right after an accept
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("second request taken while busy");

endmodule
`default_nettype wire
